### rtl/core/imu_dr_pkg.sv
// Shared types, constants and the control program of the dead-reckoning integrator.
package imu_dr_pkg;

  // Configuration register indexes and reset values
  localparam int unsigned NumRegs = 2;
  localparam int unsigned AddrW   = $clog2(NumRegs) + 2;
  localparam int unsigned ThrW    = 31;
  localparam logic REG_ACC_THR = 1'b0;
  localparam logic REG_VEL_THR = 1'b1;
  localparam logic [ThrW-1:0] ACC_THR_RESET = 31'd65536;
  localparam logic [ThrW-1:0] VEL_THR_RESET = 31'd6554;

  // Program length and step counter width
  localparam int unsigned NumSteps = 20;
  localparam int unsigned StepW    = $clog2(NumSteps);

  // Axis lanes of the vector state
  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_Z = 2'd2;

  // Multiplier operand A source
  typedef enum logic [3:0] {
    MA_AX,
    MA_AY,
    MA_AZ,
    MA_ATHR,
    MA_VX,
    MA_VY,
    MA_VZ,
    MA_VTHR,
    MA_DT
  } mul_sel_e;

  // Datapath operation on the registered product
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_VEL_ADD,
    OP_VCLAMP,
    OP_POS_ADD,
    OP_MINMAX
  } op_e;

  // One control word of the program
  typedef struct packed {
    mul_sel_e         mul_a;
    logic             mul_dt;   // operand B is dt, else operand A (square)
    op_e              op;
    logic [1:0]       lane;
    logic             jmp_below;
    logic [StepW-1:0] target;
    logic             last;
  } ucode_t;

  // Control handed from the sequencer to the datapath
  typedef struct packed {
    mul_sel_e   mul_a;
    logic       mul_dt;
    op_e        op;
    logic [1:0] lane;
  } ctrl_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] lowest_z;
    logic signed [31:0] highest_z;
  } res_t;

  function automatic ucode_t mk(mul_sel_e a, logic dt, op_e op, logic [1:0] lane,
                                logic jb, logic [StepW-1:0] tgt, logic last);
    ucode_t w;
    w.mul_a     = a;
    w.mul_dt    = dt;
    w.op        = op;
    w.lane      = lane;
    w.jmp_below = jb;
    w.target    = tgt;
    w.last      = last;
    return w;
  endfunction

  // Control program: product of step n is consumed by step n+1
  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t w;
    unique case (step)
      // squared acceleration length, then threshold squared
      5'd0:  w = mk(MA_AX,   1'b0, OP_NONE,     LANE_X, 1'b0, 5'd0,  1'b0);
      5'd1:  w = mk(MA_AY,   1'b0, OP_ACC_LOAD, LANE_X, 1'b0, 5'd0,  1'b0);
      5'd2:  w = mk(MA_AZ,   1'b0, OP_ACC_ADD,  LANE_X, 1'b0, 5'd0,  1'b0);
      5'd3:  w = mk(MA_ATHR, 1'b0, OP_ACC_ADD,  LANE_X, 1'b0, 5'd0,  1'b0);
      // below threshold: acceleration is zero, velocity stays, skip ahead
      5'd4:  w = mk(MA_DT,   1'b0, OP_NONE,     LANE_X, 1'b1, 5'd9,  1'b0);
      // velocity integration
      5'd5:  w = mk(MA_AX,   1'b1, OP_NONE,     LANE_X, 1'b0, 5'd0,  1'b0);
      5'd6:  w = mk(MA_AY,   1'b1, OP_VEL_ADD,  LANE_X, 1'b0, 5'd0,  1'b0);
      5'd7:  w = mk(MA_AZ,   1'b1, OP_VEL_ADD,  LANE_Y, 1'b0, 5'd0,  1'b0);
      5'd8:  w = mk(MA_DT,   1'b0, OP_VEL_ADD,  LANE_Z, 1'b0, 5'd0,  1'b0);
      // squared velocity length, then threshold squared
      5'd9:  w = mk(MA_VX,   1'b0, OP_NONE,     LANE_X, 1'b0, 5'd0,  1'b0);
      5'd10: w = mk(MA_VY,   1'b0, OP_ACC_LOAD, LANE_X, 1'b0, 5'd0,  1'b0);
      5'd11: w = mk(MA_VZ,   1'b0, OP_ACC_ADD,  LANE_X, 1'b0, 5'd0,  1'b0);
      5'd12: w = mk(MA_VTHR, 1'b0, OP_ACC_ADD,  LANE_X, 1'b0, 5'd0,  1'b0);
      // clamp velocity; a zero velocity leaves position as it is
      5'd13: w = mk(MA_DT,   1'b0, OP_VCLAMP,   LANE_X, 1'b1, 5'd18, 1'b0);
      // position integration
      5'd14: w = mk(MA_VX,   1'b1, OP_NONE,     LANE_X, 1'b0, 5'd0,  1'b0);
      5'd15: w = mk(MA_VY,   1'b1, OP_POS_ADD,  LANE_X, 1'b0, 5'd0,  1'b0);
      5'd16: w = mk(MA_VZ,   1'b1, OP_POS_ADD,  LANE_Y, 1'b0, 5'd0,  1'b0);
      5'd17: w = mk(MA_DT,   1'b0, OP_POS_ADD,  LANE_Z, 1'b0, 5'd0,  1'b0);
      // height extremes, then hand over the result
      5'd18: w = mk(MA_DT,   1'b0, OP_MINMAX,   LANE_X, 1'b0, 5'd0,  1'b0);
      5'd19: w = mk(MA_DT,   1'b0, OP_NONE,     LANE_X, 1'b0, 5'd0,  1'b1);
      default: w = mk(MA_DT, 1'b0, OP_NONE,     LANE_X, 1'b0, 5'd0,  1'b1);
    endcase
    return w;
  endfunction

endpackage

### rtl/core/imu_dr_seq.sv
// Step counter and program sequencer of the dead-reckoning integrator.
module imu_dr_seq import imu_dr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  below_i,
  input  logic  out_free_i,
  output logic  busy_o,
  output logic  done_o,
  output ctrl_t ctrl_o
);

  logic             run_q, run_d;
  logic [StepW-1:0] step_q, step_d;
  ucode_t           word;
  logic             hold;

  assign word = ucode_rom(step_q);
  // hold on the last step until the output register is free
  assign hold = word.last && !out_free_i;

  // decode the control word
  always_comb begin
    ctrl_o.mul_a  = word.mul_a;
    ctrl_o.mul_dt = word.mul_dt;
    ctrl_o.op     = run_q ? word.op : OP_NONE;
    ctrl_o.lane   = word.lane;
  end

  assign busy_o = run_q;
  assign done_o = run_q && word.last && out_free_i;

  // advance, jump or stop
  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    if (!run_q) begin
      if (start_i) begin
        run_d  = 1'b1;
        step_d = '0;
      end
    end else if (word.last) begin
      if (!hold) begin
        run_d = 1'b0;
      end
    end else if (word.jmp_below && below_i) begin
      step_d = word.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

endmodule

### rtl/core/imu_dr_dpath.sv
// Shared multiplier, length accumulator and integrator state of the dead-reckoning block.
module imu_dr_dpath import imu_dr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic signed [31:0] dt_i,
  input  logic signed [31:0] accel_x_i,
  input  logic signed [31:0] accel_y_i,
  input  logic signed [31:0] accel_z_i,
  input  logic [ThrW-1:0]    acc_thr_i,
  input  logic [ThrW-1:0]    vel_thr_i,
  input  ctrl_t              ctrl_i,
  output logic               below_o,
  output res_t               res_o
);

  // Saturating add of a product shifted right by 16 (floor)
  function automatic logic signed [31:0] sat_add(logic signed [31:0] base,
                                                 logic signed [63:0] prod);
    logic signed [47:0] sh;
    logic signed [48:0] sum;
    logic signed [31:0] r;
    sh  = 48'(prod >>> 16);
    sum = 49'(base) + 49'(sh);
    if (sum > 49'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (sum < -49'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = sum[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] dt_q;
  logic signed [31:0] acc_q [3];
  logic signed [31:0] vel_q [3], vel_d [3];
  logic signed [31:0] pos_q [3], pos_d [3];
  logic signed [31:0] lo_q, lo_d, hi_q, hi_d;
  logic        [63:0] sum_q, sum_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] op_a, op_b;

  // latch the sample
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dt_q     <= dt_i;
      acc_q[0] <= accel_x_i;
      acc_q[1] <= accel_y_i;
      acc_q[2] <= accel_z_i;
    end
  end

  // select multiplier operands
  always_comb begin
    case (ctrl_i.mul_a)
      MA_AX:   op_a = acc_q[0];
      MA_AY:   op_a = acc_q[1];
      MA_AZ:   op_a = acc_q[2];
      MA_ATHR: op_a = $signed({1'b0, acc_thr_i});
      MA_VX:   op_a = vel_q[0];
      MA_VY:   op_a = vel_q[1];
      MA_VZ:   op_a = vel_q[2];
      MA_VTHR: op_a = $signed({1'b0, vel_thr_i});
      default: op_a = dt_q;
    endcase
    op_b = ctrl_i.mul_dt ? dt_q : op_a;
  end

  // register the product
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  assign below_o = sum_q < $unsigned(prod_q);

  // apply the operation to the state
  always_comb begin
    sum_d = sum_q;
    vel_d = vel_q;
    pos_d = pos_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    case (ctrl_i.op)
      OP_ACC_LOAD: sum_d = $unsigned(prod_q);
      OP_ACC_ADD:  sum_d = sum_q + $unsigned(prod_q);
      OP_VEL_ADD: begin
        case (ctrl_i.lane)
          LANE_X:  vel_d[0] = sat_add(vel_q[0], prod_q);
          LANE_Y:  vel_d[1] = sat_add(vel_q[1], prod_q);
          LANE_Z:  vel_d[2] = sat_add(vel_q[2], prod_q);
          default: ;
        endcase
      end
      OP_VCLAMP: begin
        if (below_o) begin
          vel_d[0] = '0;
          vel_d[1] = '0;
          vel_d[2] = '0;
        end
      end
      OP_POS_ADD: begin
        case (ctrl_i.lane)
          LANE_X:  pos_d[0] = sat_add(pos_q[0], prod_q);
          LANE_Y:  pos_d[1] = sat_add(pos_q[1], prod_q);
          LANE_Z:  pos_d[2] = sat_add(pos_q[2], prod_q);
          default: ;
        endcase
      end
      OP_MINMAX: begin
        if (pos_q[2] < lo_q) lo_d = pos_q[2];
        if (pos_q[2] > hi_q) hi_d = pos_q[2];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '{default: '0};
      pos_q <= '{default: '0};
      lo_q  <= '0;
      hi_q  <= '0;
    end else begin
      vel_q <= vel_d;
      pos_q <= pos_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
  end

  // present the state as a result word
  always_comb begin
    res_o.pos_x     = pos_q[0];
    res_o.pos_y     = pos_q[1];
    res_o.pos_z     = pos_q[2];
    res_o.vel_x     = vel_q[0];
    res_o.vel_y     = vel_q[1];
    res_o.vel_z     = vel_q[2];
    res_o.lowest_z  = lo_q;
    res_o.highest_z = hi_q;
  end

endmodule

### rtl/core/imu_dead_reckoning_integrator.sv
// Top level of the dead-reckoning integrator: handshakes, registers, sample gating, result word.
//
//   channel  direction  handshake                  word
//   in       input      in_valid_i / in_stall_o    timestamp, accel_x/y/z
//   out      output     out_valid_o / out_stall_i  pos_x/y/z, vel_x/y/z, lowest_z, highest_z
//   cfg      input      APB psel/penable/pready    thresholds at 0x0 and 0x4
//
// A word that is integrated runs a 20-step program on one shared 32x32 multiplier; the velocity
// steps are skipped when acceleration is clamped, the position steps when velocity is clamped.
// The first word after reset and a word with a negative time step are not integrated.
// Reset clears the integrator state and the output valid flag and restores the thresholds; no clearing pass.
// A new word is taken while a result waits; the program holds on its last step
// while out_stall_i keeps the previous result in place.
module imu_dead_reckoning_integrator import imu_dr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        timestamp_i,
  input  logic signed [31:0] accel_x_i,
  input  logic signed [31:0] accel_y_i,
  input  logic signed [31:0] accel_z_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic signed [31:0] lowest_z_o,
  output logic signed [31:0] highest_z_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [ThrW-1:0] acc_thr_q, vel_thr_q;
  logic            started_q;
  logic [31:0]     prev_time_q;
  logic            accept, start, busy, done, below, out_free;
  logic [31:0]     dt;
  logic            reg_sel;
  ctrl_t           ctrl;
  res_t            res, out_q;
  logic            out_valid_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrW-1];

  always_comb begin
    unique case (reg_sel)
      REG_ACC_THR: prdata = {1'b0, acc_thr_q};
      REG_VEL_THR: prdata = {1'b0, vel_thr_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_thr_q <= ACC_THR_RESET;
      vel_thr_q <= VEL_THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_ACC_THR: acc_thr_q <= pwdata[ThrW-1:0];
        REG_VEL_THR: vel_thr_q <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // gate the sample: first word only stamps time, negative step is dropped
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign dt         = timestamp_i - prev_time_q;
  assign start      = accept && started_q && !dt[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      prev_time_q <= '0;
    end else if (accept && (!started_q || !dt[31])) begin
      started_q   <= 1'b1;
      prev_time_q <= timestamp_i;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  imu_dr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .below_i    (below),
    .out_free_i (out_free),
    .busy_o     (busy),
    .done_o     (done),
    .ctrl_o     (ctrl)
  );

  imu_dr_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (start),
    .dt_i      ($signed(dt)),
    .accel_x_i (accel_x_i),
    .accel_y_i (accel_y_i),
    .accel_z_i (accel_z_i),
    .acc_thr_i (acc_thr_q),
    .vel_thr_i (vel_thr_q),
    .ctrl_i    (ctrl),
    .below_o   (below),
    .res_o     (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_q.pos_x;
  assign pos_y_o     = out_q.pos_y;
  assign pos_z_o     = out_q.pos_z;
  assign vel_x_o     = out_q.vel_x;
  assign vel_y_o     = out_q.vel_y;
  assign vel_z_o     = out_q.vel_z;
  assign lowest_z_o  = out_q.lowest_z;
  assign highest_z_o = out_q.highest_z;

endmodule
